>>> design/gda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_pkg: Gregorian date arithmetic shared definitions
// Beat types, operation codes, microcode encoding, program and calendar tables.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int COUNT_WIDTH = 20;
	localparam int CNT_USED    = (COUNT_WIDTH < 20) ? COUNT_WIDTH : 20;

	localparam int SER_W = 24;
	localparam int YR_W  = 15;
	localparam int PC_W  = 4;

	localparam logic [YR_W-1:0]  YEAR_BIAS = YR_W'(4000);
	localparam logic [YR_W-1:0]  YEAR_MAX  = YR_W'(9999);
	localparam logic [SER_W-1:0] DIFF_MAX  = SER_W'(4194303);

	localparam logic [SER_W-1:0] D400 = SER_W'(146097);
	localparam logic [SER_W-1:0] D100 = SER_W'(36524);
	localparam logic [SER_W-1:0] D4   = SER_W'(1461);
	localparam logic [SER_W-1:0] D1   = SER_W'(365);

	localparam logic [YR_W-1:0] Y400 = YR_W'(400);
	localparam logic [YR_W-1:0] Y100 = YR_W'(100);
	localparam logic [YR_W-1:0] Y4   = YR_W'(4);
	localparam logic [YR_W-1:0] Y1   = YR_W'(1);

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [19:0] day_count;
		logic [4:0]  other_day;
		logic [3:0]  other_month;
		logic [13:0] other_year;
	} gda_cmd_t;

	typedef struct packed {
		logic [4:0]  result_day;
		logic [3:0]  result_month;
		logic [13:0] result_year;
		logic [21:0] day_difference;
		logic        out_of_range;
	} gda_res_t;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_SUB  = 2'd1;
	localparam logic [1:0] OP_DIFF = 2'd2;
	localparam logic [1:0] OP_BAD  = 2'd3;

	// datapath functions
	localparam logic [3:0] F_LOAD_A = 4'd0;
	localparam logic [3:0] F_Y400   = 4'd1;
	localparam logic [3:0] F_Y100   = 4'd2;
	localparam logic [3:0] F_Y4     = 4'd3;
	localparam logic [3:0] F_Y1     = 4'd4;
	localparam logic [3:0] F_MDAY   = 4'd5;
	localparam logic [3:0] F_NOP    = 4'd6;
	localparam logic [3:0] F_LOAD_B = 4'd7;
	localparam logic [3:0] F_DIFF   = 4'd8;
	localparam logic [3:0] F_ADDSUB = 4'd9;
	localparam logic [3:0] F_I400   = 4'd10;
	localparam logic [3:0] F_I100   = 4'd11;
	localparam logic [3:0] F_I4     = 4'd12;
	localparam logic [3:0] F_I1     = 4'd13;
	localparam logic [3:0] F_MWALK  = 4'd14;
	localparam logic [3:0] F_EMIT   = 4'd15;

	// sequencing modes
	localparam logic [1:0] NX_SEQ  = 2'd0;
	localparam logic [1:0] NX_LOOP = 2'd1;
	localparam logic [1:0] NX_JIF  = 2'd2;
	localparam logic [1:0] NX_END  = 2'd3;

	// condition selects
	localparam logic [3:0] C_TRUE   = 4'd0;
	localparam logic [3:0] C_Y400   = 4'd1;
	localparam logic [3:0] C_Y100   = 4'd2;
	localparam logic [3:0] C_Y4     = 4'd3;
	localparam logic [3:0] C_Y1     = 4'd4;
	localparam logic [3:0] C_S400   = 4'd5;
	localparam logic [3:0] C_S100   = 4'd6;
	localparam logic [3:0] C_S4     = 4'd7;
	localparam logic [3:0] C_S1     = 4'd8;
	localparam logic [3:0] C_MON    = 4'd9;
	localparam logic [3:0] C_DSELB  = 4'd10;
	localparam logic [3:0] C_ADDSUB = 4'd11;
	localparam logic [3:0] C_BADOP  = 4'd12;

	// program steps
	localparam logic [PC_W-1:0] ST_LOAD_A = PC_W'(0);
	localparam logic [PC_W-1:0] ST_Y400   = PC_W'(1);
	localparam logic [PC_W-1:0] ST_Y100   = PC_W'(2);
	localparam logic [PC_W-1:0] ST_Y4     = PC_W'(3);
	localparam logic [PC_W-1:0] ST_Y1     = PC_W'(4);
	localparam logic [PC_W-1:0] ST_MDAY   = PC_W'(5);
	localparam logic [PC_W-1:0] ST_DISP   = PC_W'(6);
	localparam logic [PC_W-1:0] ST_LOAD_B = PC_W'(7);
	localparam logic [PC_W-1:0] ST_DIFF   = PC_W'(8);
	localparam logic [PC_W-1:0] ST_ADDSUB = PC_W'(9);
	localparam logic [PC_W-1:0] ST_I400   = PC_W'(10);
	localparam logic [PC_W-1:0] ST_I100   = PC_W'(11);
	localparam logic [PC_W-1:0] ST_I4     = PC_W'(12);
	localparam logic [PC_W-1:0] ST_I1     = PC_W'(13);
	localparam logic [PC_W-1:0] ST_MWALK  = PC_W'(14);
	localparam logic [PC_W-1:0] ST_EMIT   = PC_W'(15);

	typedef struct packed {
		logic [3:0]      func;
		logic [1:0]      nxt;
		logic [3:0]      cnd;
		logic [PC_W-1:0] tgt;
	} gda_uop_t;

	function automatic gda_uop_t ucode(input logic [PC_W-1:0] pc);
		gda_uop_t u;
		unique case (pc)
			ST_LOAD_A: u = '{F_LOAD_A, NX_JIF,  C_BADOP,  ST_DIFF};
			ST_Y400:   u = '{F_Y400,   NX_LOOP, C_Y400,   ST_Y400};
			ST_Y100:   u = '{F_Y100,   NX_LOOP, C_Y100,   ST_Y100};
			ST_Y4:     u = '{F_Y4,     NX_LOOP, C_Y4,     ST_Y4};
			ST_Y1:     u = '{F_Y1,     NX_LOOP, C_Y1,     ST_Y1};
			ST_MDAY:   u = '{F_MDAY,   NX_JIF,  C_DSELB,  ST_DIFF};
			ST_DISP:   u = '{F_NOP,    NX_JIF,  C_ADDSUB, ST_ADDSUB};
			ST_LOAD_B: u = '{F_LOAD_B, NX_JIF,  C_TRUE,   ST_Y400};
			ST_DIFF:   u = '{F_DIFF,   NX_END,  C_TRUE,   ST_LOAD_A};
			ST_ADDSUB: u = '{F_ADDSUB, NX_SEQ,  C_TRUE,   ST_I400};
			ST_I400:   u = '{F_I400,   NX_LOOP, C_S400,   ST_I400};
			ST_I100:   u = '{F_I100,   NX_LOOP, C_S100,   ST_I100};
			ST_I4:     u = '{F_I4,     NX_LOOP, C_S4,     ST_I4};
			ST_I1:     u = '{F_I1,     NX_LOOP, C_S1,     ST_I1};
			ST_MWALK:  u = '{F_MWALK,  NX_LOOP, C_MON,    ST_MWALK};
			ST_EMIT:   u = '{F_EMIT,   NX_END,  C_TRUE,   ST_LOAD_A};
		endcase
		return u;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] mi);
		logic [8:0] v;
		case (mi)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd59;
			4'd3:    v = 9'd90;
			4'd4:    v = 9'd120;
			4'd5:    v = 9'd151;
			4'd6:    v = 9'd181;
			4'd7:    v = 9'd212;
			4'd8:    v = 9'd243;
			4'd9:    v = 9'd273;
			4'd10:   v = 9'd304;
			4'd11:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mi);
		logic [4:0] v;
		case (mi)
			4'd1:                        v = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:     v = 5'd30;
			default:                     v = 5'd31;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> design/gregorian_date_arithmetic_core.sv
`default_nettype none
// One microcode step runs per cycle; an add or subtract takes one step per 400-, 100-, 4- and
// 1-year split of each date and per month walked; a difference takes one step per year split
// of both dates.
// A new start is taken in the cycle done is high; no new item is taken while busy is high.
// The date walk loops run on the single shared year/day datapath.
// Reset clears busy, done and the step counter; the result payload is not reset.
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Microcoded Gregorian date add, subtract and day difference unit.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core import gda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  gda_cmd_t cmd,
	output logic     busy,
	output logic     done,
	output gda_res_t rsp
);

	logic            busy_q;
	logic            done_q;
	logic [PC_W-1:0] pc_q;
	gda_cmd_t        cmd_q;
	gda_res_t        res_q;
	logic            dsel_q;
	logic [YR_W-1:0] yr_q;
	logic [SER_W-1:0] sr_q;
	logic [SER_W-1:0] s1_q;
	logic [1:0]      c100_q;
	logic [4:0]      c4_q;
	logic [1:0]      c1_q;
	logic [3:0]      mi_q;

	gda_uop_t        uop;
	logic            cond;
	logic            act;
	logic            leap;
	logic [4:0]      sel_day;
	logic [3:0]      sel_month;
	logic [3:0]      mi_sel;
	logic [4:0]      mlen;
	logic [SER_W-1:0] mday_sum;
	logic [SER_W-1:0] count_ext;
	logic [SER_W-1:0] diff;
	logic [YR_W-1:0] yb;
	logic [13:0]     year_out;
	logic            year_oor;

	assign uop       = ucode(pc_q);
	assign leap      = (c1_q == 2'd3) && ((c4_q != 5'd24) || (c100_q == 2'd3));
	assign sel_day   = dsel_q ? cmd_q.other_day : cmd_q.start_day;
	assign sel_month = dsel_q ? cmd_q.other_month : cmd_q.start_month;
	assign count_ext = SER_W'(cmd_q.day_count[CNT_USED-1:0]);
	assign mlen      = month_len(mi_q) + 5'((mi_q == 4'd1) && leap);
	assign diff      = (s1_q > sr_q) ? (s1_q - sr_q) : (sr_q - s1_q);
	assign yb        = yr_q + Y1;

	always_comb begin
		priority if (sel_month == 4'd0) begin
			mi_sel = 4'd0;
		end else if (sel_month > 4'd12) begin
			mi_sel = 4'd11;
		end else begin
			mi_sel = sel_month - 4'd1;
		end
	end

	assign mday_sum = sr_q + SER_W'(month_start(mi_sel)) + SER_W'(leap && (mi_sel >= 4'd2))
		+ SER_W'(sel_day) - SER_W'(1);

	always_comb begin
		priority if (yb <= YEAR_BIAS) begin
			year_out = 14'd1;
			year_oor = 1'b1;
		end else if (yb > YEAR_BIAS + YEAR_MAX) begin
			year_out = 14'(YEAR_MAX);
			year_oor = 1'b1;
		end else begin
			year_out = 14'(yb - YEAR_BIAS);
			year_oor = 1'b0;
		end
	end

	always_comb begin
		case (uop.cnd)
			C_TRUE:   cond = 1'b1;
			C_Y400:   cond = (yr_q >= Y400);
			C_Y100:   cond = (yr_q >= Y100);
			C_Y4:     cond = (yr_q >= Y4);
			C_Y1:     cond = (yr_q >= Y1);
			C_S400:   cond = (sr_q >= D400);
			C_S100:   cond = (sr_q >= D100) && (c100_q != 2'd3);
			C_S4:     cond = (sr_q >= D4);
			C_S1:     cond = (sr_q >= D1) && (c1_q != 2'd3);
			C_MON:    cond = (mi_q != 4'd11) && (sr_q >= SER_W'(mlen));
			C_DSELB:  cond = dsel_q;
			C_ADDSUB: cond = (cmd_q.operation == OP_ADD) || (cmd_q.operation == OP_SUB);
			C_BADOP:  cond = (cmd_q.operation == OP_BAD);
			default:  cond = 1'b0;
		endcase
	end

	assign act = (uop.nxt != NX_LOOP) || cond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pc_q   <= ST_LOAD_A;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					pc_q   <= ST_LOAD_A;
				end
			end else begin
				unique case (uop.nxt)
					NX_SEQ:  pc_q <= pc_q + PC_W'(1);
					NX_LOOP: pc_q <= cond ? pc_q : pc_q + PC_W'(1);
					NX_JIF:  pc_q <= cond ? uop.tgt : pc_q + PC_W'(1);
					NX_END: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						pc_q   <= ST_LOAD_A;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			cmd_q <= cmd;
		end
		if (busy_q && act) begin
			unique case (uop.func)
				F_LOAD_A: begin
					yr_q   <= YR_W'(cmd_q.start_year) + YEAR_BIAS - Y1;
					sr_q   <= '0;
					c100_q <= '0;
					c4_q   <= '0;
					c1_q   <= '0;
					dsel_q <= 1'b0;
				end
				F_LOAD_B: begin
					yr_q   <= YR_W'(cmd_q.other_year) + YEAR_BIAS - Y1;
					sr_q   <= '0;
					c100_q <= '0;
					c4_q   <= '0;
					c1_q   <= '0;
					dsel_q <= 1'b1;
				end
				F_Y400: begin
					yr_q <= yr_q - Y400;
					sr_q <= sr_q + D400;
				end
				F_Y100: begin
					yr_q   <= yr_q - Y100;
					sr_q   <= sr_q + D100;
					c100_q <= c100_q + 2'd1;
				end
				F_Y4: begin
					yr_q <= yr_q - Y4;
					sr_q <= sr_q + D4;
					c4_q <= c4_q + 5'd1;
				end
				F_Y1: begin
					yr_q <= yr_q - Y1;
					sr_q <= sr_q + D1;
					c1_q <= c1_q + 2'd1;
				end
				F_MDAY: begin
					sr_q <= mday_sum;
					if (!dsel_q) begin
						s1_q <= mday_sum;
					end
				end
				F_NOP: begin
				end
				F_DIFF: begin
					res_q.result_day   <= '0;
					res_q.result_month <= '0;
					res_q.result_year  <= '0;
					if (cmd_q.operation != OP_DIFF) begin
						res_q.day_difference <= '0;
						res_q.out_of_range   <= 1'b0;
					end else if (diff > DIFF_MAX) begin
						res_q.day_difference <= 22'(DIFF_MAX);
						res_q.out_of_range   <= 1'b1;
					end else begin
						res_q.day_difference <= 22'(diff);
						res_q.out_of_range   <= 1'b0;
					end
				end
				F_ADDSUB: begin
					sr_q   <= (cmd_q.operation == OP_SUB) ? s1_q - count_ext : s1_q + count_ext;
					yr_q   <= '0;
					c100_q <= '0;
					c4_q   <= '0;
					c1_q   <= '0;
					mi_q   <= '0;
				end
				F_I400: begin
					sr_q <= sr_q - D400;
					yr_q <= yr_q + Y400;
				end
				F_I100: begin
					sr_q   <= sr_q - D100;
					yr_q   <= yr_q + Y100;
					c100_q <= c100_q + 2'd1;
				end
				F_I4: begin
					sr_q <= sr_q - D4;
					yr_q <= yr_q + Y4;
					c4_q <= c4_q + 5'd1;
				end
				F_I1: begin
					sr_q <= sr_q - D1;
					yr_q <= yr_q + Y1;
					c1_q <= c1_q + 2'd1;
				end
				F_MWALK: begin
					sr_q <= sr_q - SER_W'(mlen);
					mi_q <= mi_q + 4'd1;
				end
				F_EMIT: begin
					res_q.result_day     <= 5'(sr_q) + 5'd1;
					res_q.result_month   <= mi_q + 4'd1;
					res_q.result_year    <= year_out;
					res_q.day_difference <= '0;
					res_q.out_of_range   <= year_oor;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = res_q;

endmodule
`default_nettype wire

>>> design/gda_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_checker
// Port-level checks of the date arithmetic core handshake and result beats.
// ----------------------------------------------------------------------------
module gda_checker import gda_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     done,
	input wire gda_res_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result beat not at the end of a busy period");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.day_difference == 22'd0) ||
			((rsp.result_day == 5'd0) && (rsp.result_month == 4'd0) &&
			(rsp.result_year == 14'd0))))
		else $error("result beat carries both a date and a difference");

endmodule

bind gregorian_date_arithmetic_core gda_checker u_gda_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
`default_nettype wire

>>> sim/tb_gregorian_date_arithmetic_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_arithmetic_core
// Self-checking bench for the date add, subtract and day difference unit.
// Directed dates cover calendar edges, leap rules, month/day normalization,
// year saturation, difference saturation and the invalid operation. A long
// random phase follows. Every result is checked against an in-bench
// calendar predictor, with random idle gaps on the command side.
// ----------------------------------------------------------------------------
module tb_gregorian_date_arithmetic_core;
	import gda_pkg::*;

	localparam int     CLK_HALF     = 2;
	localparam int     CYCLE_LIMIT  = 1_000_000;
	localparam int     TAIL_CYCLES  = 200;
	localparam int     RANDOM_ITEMS = 480;
	localparam longint CAL_BIAS     = 64'd12000000;
	localparam longint DIST_MAX     = 64'd4194303;

	logic     clk;
	logic     arst_n;
	logic     start;
	gda_cmd_t cmd;
	logic     busy;
	logic     done;
	gda_res_t rsp;

	gda_res_t    pending_results[$];
	gda_res_t    want_res;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned oor_seen;
	int unsigned beats_add, beats_sub, beats_diff, beats_bad;

	gregorian_date_arithmetic_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------------
	function automatic bit leap_year(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint days_in_month(int mi, bit leap);
		case (mi)
			1:           return leap ? 64'd29 : 64'd28;
			3, 5, 8, 10: return 64'd30;
			default:     return 64'd31;
		endcase
	endfunction

	function automatic longint days_before_jan1(longint y);
		longint p;
		p = y - 1;
		return p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic longint day_serial(logic [4:0] d, logic [3:0] m, logic [13:0] y);
		longint yb, s;
		int     mi;
		yb = longint'(y) + CAL_BIAS;
		if (m == 4'd0)
			mi = 0;
		else if (m > 4'd12)
			mi = 11;
		else
			mi = int'(m) - 1;
		s = days_before_jan1(yb);
		for (int k = 0; k < mi; k++)
			s += days_in_month(k, leap_year(yb));
		return s + longint'(d) - 1;
	endfunction

	function automatic gda_res_t predict_date_result(gda_cmd_t c);
		gda_res_t r;
		longint   s1, s2, s, cnt, yb, doy, y, span;
		int       mi;
		r   = '0;
		s1  = day_serial(c.start_day, c.start_month, c.start_year);
		cnt = longint'(c.day_count);
		case (c.operation)
			OP_ADD, OP_SUB: begin
				s  = (c.operation == OP_ADD) ? s1 + cnt : s1 - cnt;
				yb = (s * 400) / 146097 + 1;
				if (yb < 1)
					yb = 1;
				while (yb > 1 && days_before_jan1(yb) > s)
					yb--;
				while (days_before_jan1(yb + 1) <= s)
					yb++;
				doy = s - days_before_jan1(yb);
				mi  = 0;
				while (mi < 11 && doy >= days_in_month(mi, leap_year(yb))) begin
					doy -= days_in_month(mi, leap_year(yb));
					mi++;
				end
				y = yb - CAL_BIAS;
				r.result_day   = 5'(doy + 1);
				r.result_month = 4'(mi + 1);
				if (y < 1) begin
					y = 1;
					r.out_of_range = 1'b1;
				end
				if (y > 9999) begin
					y = 9999;
					r.out_of_range = 1'b1;
				end
				r.result_year = 14'(y);
			end
			OP_DIFF: begin
				s2   = day_serial(c.other_day, c.other_month, c.other_year);
				span = (s1 > s2) ? s1 - s2 : s2 - s1;
				if (span > DIST_MAX) begin
					span = DIST_MAX;
					r.out_of_range = 1'b1;
				end
				r.day_difference = 22'(span);
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------------
	function automatic gda_cmd_t make_cmd(logic [1:0] op, logic [4:0] d, logic [3:0] m,
		logic [13:0] y, logic [19:0] cnt, logic [4:0] od, logic [3:0] om, logic [13:0] oy);
		gda_cmd_t c;
		c.operation   = op;
		c.start_day   = d;
		c.start_month = m;
		c.start_year  = y;
		c.day_count   = cnt;
		c.other_day   = od;
		c.other_month = om;
		c.other_year  = oy;
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(50, 300);
	endfunction

	task automatic send_cmd(gda_cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_date_result(c));
		case (c.operation)
			OP_ADD:  beats_add++;
			OP_SUB:  beats_sub++;
			OP_DIFF: beats_diff++;
			default: beats_bad++;
		endcase
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_gapped(gda_cmd_t c);
		send_cmd(c);
		idle_cycles(pick_gap());
	endtask

	// drop start, then hold until every result is back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (rsp.out_of_range)
				oor_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat at cycle %0d", cycle_count);
			end else begin
				want_res = pending_results.pop_front();
				if (rsp.result_day !== want_res.result_day ||
				    rsp.result_month !== want_res.result_month ||
				    rsp.result_year !== want_res.result_year ||
				    rsp.day_difference !== want_res.day_difference ||
				    rsp.out_of_range !== want_res.out_of_range) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at cycle %0d: expected %0d/%0d/%0d dist %0d oor %0d",
							cycle_count, want_res.result_day, want_res.result_month,
							want_res.result_year, want_res.day_difference,
							want_res.out_of_range);
						$display("  got %0d/%0d/%0d dist %0d oor %0d",
							rsp.result_day, rsp.result_month, rsp.result_year,
							rsp.day_difference, rsp.out_of_range);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_add_edges();
		send_gapped(make_cmd(OP_ADD, 5'd1, 4'd1, 14'd1, 20'd0, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd31, 4'd12, 14'd1999, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd28, 4'd2, 14'd2000, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd28, 4'd2, 14'd1900, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd31, 4'd12, 14'd9999, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd1, 4'd1, 14'd1, 20'hFFFFF, 5'd0, 4'd0, 14'd0));
	endtask

	task automatic test_subtract_edges();
		send_gapped(make_cmd(OP_SUB, 5'd1, 4'd1, 14'd1, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_SUB, 5'd1, 4'd3, 14'd2004, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_SUB, 5'd1, 4'd3, 14'd2100, 20'd1, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_SUB, 5'd31, 4'd2, 14'd2001, 20'd0, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_SUB, 5'd31, 4'd12, 14'd9999, 20'hFFFFF, 5'd0, 4'd0, 14'd0));
	endtask

	task automatic test_difference_edges();
		send_gapped(make_cmd(OP_DIFF, 5'd15, 4'd6, 14'd2024, 20'd0, 5'd15, 4'd6, 14'd2024));
		send_gapped(make_cmd(OP_DIFF, 5'd1, 4'd1, 14'd2000, 20'd0, 5'd1, 4'd1, 14'd2001));
		send_gapped(make_cmd(OP_DIFF, 5'd1, 4'd1, 14'd0, 20'd0, 5'd31, 4'd15, 14'h3FFF));
		send_gapped(make_cmd(OP_DIFF, 5'd0, 4'd0, 14'd1, 20'hFFFFF, 5'd31, 4'd15, 14'd9999));
		send_gapped(make_cmd(OP_DIFF, 5'd31, 4'd12, 14'd9999, 20'd5, 5'd1, 4'd1, 14'd1));
	endtask

	task automatic test_special_cases();
		send_gapped(make_cmd(OP_BAD, 5'd0, 4'd0, 14'd0, 20'd0, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_BAD, 5'h1F, 4'hF, 14'h3FFF, 20'hFFFFF, 5'h1F, 4'hF, 14'h3FFF));
		send_gapped(make_cmd(OP_ADD, 5'd0, 4'd0, 14'd0, 20'd0, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd31, 4'd15, 14'h3FFF, 20'hFFFFF, 5'h1F, 4'hF, 14'h3FFF));
		send_gapped(make_cmd(OP_SUB, 5'd0, 4'd3, 14'd0, 20'd0, 5'd0, 4'd0, 14'd0));
		send_gapped(make_cmd(OP_ADD, 5'd31, 4'd2, 14'd2000, 20'd0, 5'd0, 4'd0, 14'd0));
	endtask

	task automatic random_date(output logic [4:0] d, output logic [3:0] m,
		output logic [13:0] y);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			d = 5'($urandom_range(1, 28));
			m = 4'($urandom_range(1, 12));
			y = 14'($urandom_range(1, 9999));
		end else if (r < 88) begin
			d = 5'($urandom_range(1, 31));
			m = 4'($urandom_range(1, 12));
			y = ($urandom_range(0, 1)) ? 14'($urandom_range(1, 3))
			                           : 14'($urandom_range(9997, 9999));
		end else begin
			d = 5'($urandom);
			m = 4'($urandom);
			y = 14'($urandom);
		end
	endtask

	task automatic test_random_mix();
		gda_cmd_t c;
		int       r;
		bit       burst;
		burst = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			r = $urandom_range(0, 9);
			if (r < 4)
				c.operation = OP_ADD;
			else if (r < 7)
				c.operation = OP_SUB;
			else if (r < 9)
				c.operation = OP_DIFF;
			else
				c.operation = 2'($urandom);
			random_date(c.start_day, c.start_month, c.start_year);
			r = $urandom_range(0, 9);
			if (r == 0)
				c.day_count = 20'($urandom_range(0, 31));
			else if (r < 5)
				c.day_count = 20'($urandom_range(0, 400));
			else if (r < 8)
				c.day_count = 20'($urandom_range(0, 50000));
			else if (r == 8)
				c.day_count = 20'($urandom);
			else
				c.day_count = 20'hFFFFF - 20'($urandom_range(0, 16));
			if ($urandom_range(0, 1)) begin
				random_date(c.other_day, c.other_month, c.other_year);
			end else begin
				c.other_day   = 5'($urandom_range(1, 28));
				c.other_month = 4'($urandom_range(1, 12));
				c.other_year  = c.start_year + 14'($urandom_range(0, 20)) - 14'd10;
			end
			send_cmd(c);
			if (!burst)
				idle_cycles(pick_gap());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cycle_count  = 0;
		mismatches   = 0;
		results_seen = 0;
		oor_seen     = 0;
		beats_add    = 0;
		beats_sub    = 0;
		beats_diff   = 0;
		beats_bad    = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_add_edges();
		test_subtract_edges();
		drain_results();
		test_difference_edges();
		test_special_cases();
		drain_results();
		test_random_mix();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d beats: %0d add, %0d subtract, %0d difference, %0d invalid op",
			beats_add + beats_sub + beats_diff + beats_bad, beats_add, beats_sub,
			beats_diff, beats_bad);
		$display("%0d results checked, %0d flagged out of range, %0d mismatches",
			results_seen, oor_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
